[hdl/blti_pkg.sv]
package blti_pkg;

   localparam int TableEntries = 16;
   localparam int MaxDegrees   = 4;
   localparam int FracBits     = 16;
   localparam int IdxW         = $clog2(TableEntries);
   localparam int UsedW        = $clog2(TableEntries + 1);
   localparam int LimW         = $clog2(MaxDegrees);
   localparam int ToleranceReset = 7;
   // One quotient bit per step: 32 integer bits plus the fraction
   localparam int DivSteps     = 32 + FracBits;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_ANSWER   = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_CLEARED  = 2'd3
   } status_type;

   // Source of the response fields
   typedef enum logic [1:0] {
      SEL_ZERO  = 2'd0,
      SEL_FOUND = 2'd1,
      SEL_LERP  = 2'd2
   } sel_type;

   localparam logic CFG_LERP = 1'b0;
   localparam logic CFG_TOL  = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             load_req;     // capture the request fields
      logic             clear_used;   // empty the table
      logic             shift_step;   // move entry idx-1 up to idx
      logic             write_new;    // write captured entry at idx
      logic             rd_found;     // read entry idx into A registers
      logic             rd_next;      // read entry idx into B registers
      logic             div_start;    // start the divider
      logic             div_step;     // one restoring step
      logic             mul_step;     // one lane of multiply
      logic             fin_step;     // accumulate one lane
      logic [LimW:0]    lane;         // lane 0 is distance, 1.. limits
      logic [IdxW-1:0]  idx;
      sel_type          rsp_sel;
      status_type       status;
      logic             rsp_load;
   } cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic [UsedW-1:0] used;
      opcode_type       op;
      logic             prev_gt;      // entry idx-1 distance > new
      logic             le_bound;     // entry idx distance <= bound
      logic             lerp;
   } stat_type;

endpackage

[hdl/blti_ctrl.sv]
module blti_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  blti_pkg::stat_type stat,
   output blti_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SHIFT, S_WRITE, S_SEARCH, S_RDA, S_RDB, S_DIVST,
      S_DIV, S_MUL, S_FIN, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [blti_pkg::IdxW-1:0] idx_ff, idx_in;
   logic [blti_pkg::IdxW-1:0] found_ff, found_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [blti_pkg::LimW:0] lane_ff, lane_in;
   logic rsp_valid_ff, rsp_valid_in;
   blti_pkg::status_type rsp_status_ff, rsp_status_in;
   blti_pkg::sel_type rsp_sel_ff, rsp_sel_in;
   blti_pkg::cmd_type c;

   localparam logic [blti_pkg::LimW:0] LastLane = (blti_pkg::LimW+1)'(blti_pkg::MaxDegrees);
   localparam logic [blti_pkg::IdxW-1:0] LastIdx = blti_pkg::IdxW'(blti_pkg::TableEntries - 1);
   localparam logic [5:0] LastStep = 6'(blti_pkg::DivSteps - 1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign cmd = c;

   // Sequence each request: clear, insert with shift and write, or query with search, divide and lerp steps
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      cnt_in = cnt_ff;
      lane_in = lane_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sel_in = rsp_sel_ff;
      c = '0;
      c.idx = idx_ff;
      c.lane = lane_ff;
      c.status = rsp_status_ff;
      c.rsp_sel = rsp_sel_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               c.load_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rsp_status_in = blti_pkg::ST_ANSWER;
            rsp_sel_in = blti_pkg::SEL_ZERO;
            unique case (stat.op)
               blti_pkg::OP_CLEAR: begin
                  c.clear_used = 1'b1;
                  rsp_status_in = blti_pkg::ST_CLEARED;
                  state_in = S_RESP;
               end
               blti_pkg::OP_INSERT: begin
                  if (stat.used >= blti_pkg::UsedW'(blti_pkg::TableEntries)) begin
                     rsp_status_in = blti_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     idx_in = stat.used[blti_pkg::IdxW-1:0];
                     state_in = S_SHIFT;
                  end
               end
               blti_pkg::OP_QUERY: begin
                  idx_in = '0;
                  found_in = '0;
                  state_in = (stat.used == '0) ? S_RESP : S_SEARCH;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SHIFT: begin
            if (idx_ff != '0 && stat.prev_gt) begin
               c.shift_step = 1'b1;
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            c.write_new = 1'b1;
            rsp_status_in = blti_pkg::ST_INSERTED;
            state_in = S_RESP;
         end
         S_SEARCH: begin
            if (stat.le_bound) found_in = idx_ff;
            if ((blti_pkg::UsedW)'(idx_ff) + 1'b1 >= stat.used) begin
               idx_in = stat.le_bound ? idx_ff : found_ff;
               state_in = S_RDA;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RDA: begin
            c.rd_found = 1'b1;
            if (stat.lerp && (blti_pkg::UsedW)'(idx_ff) + 1'b1 < stat.used
                && idx_ff != LastIdx) begin
               idx_in = idx_ff + 1'b1;
               state_in = S_RDB;
            end else begin
               rsp_sel_in = blti_pkg::SEL_FOUND;
               state_in = S_RESP;
            end
         end
         S_RDB: begin
            c.rd_next = 1'b1;
            state_in = S_DIVST;
         end
         S_DIVST: begin
            c.div_start = 1'b1;
            cnt_in = 6'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            c.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               lane_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            c.mul_step = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            c.fin_step = 1'b1;
            if (lane_ff == LastLane) begin
               rsp_sel_in = blti_pkg::SEL_LERP;
               state_in = S_RESP;
            end else begin
               lane_in = lane_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_RESP: begin
            // hold the result until the previous response has left
            if (!rsp_valid_ff || rsp_tready) begin
               c.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
         found_ff <= '0;
         cnt_ff <= '0;
         lane_ff <= '0;
         rsp_status_ff <= blti_pkg::ST_ANSWER;
         rsp_sel_ff <= blti_pkg::SEL_ZERO;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         cnt_ff <= cnt_in;
         lane_ff <= lane_in;
         rsp_status_ff <= rsp_status_in;
         rsp_sel_ff <= rsp_sel_in;
      end
   end

endmodule

[hdl/blti_dp.sv]
module blti_dp (
   input  logic               clock,
   input  logic               reset,
   input  blti_pkg::cmd_type  cmd,
   output blti_pkg::stat_type stat,
   input  logic [167:0]       req_tdata,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   output logic [167:0]       rsp_tdata
);

   localparam int NL = blti_pkg::MaxDegrees;
   localparam int FB = blti_pkg::FracBits;
   localparam int QW = blti_pkg::DivSteps;

   // Table storage: one row per entry
   logic signed [31:0] dist_mem [blti_pkg::TableEntries];
   logic [2:0]         cnt_mem  [blti_pkg::TableEntries];
   logic signed [31:0] lim_mem  [blti_pkg::TableEntries][NL];

   logic [blti_pkg::UsedW-1:0] used_ff;
   logic lerp_ff;
   logic [15:0] tol_ff;

   logic [1:0] op_ff;
   logic signed [31:0] q_ff;
   logic signed [31:0] nl_ff [NL];
   logic [2:0] ncnt_ff;

   logic signed [31:0] da_ff, db_ff;
   logic signed [31:0] la_ff [NL];
   logic signed [31:0] lb_ff [NL];
   logic [2:0] ca_ff;

   // divider
   logic [QW-1:0] quo_ff;
   logic [31:0] rem_ff, den_ff;
   logic neg_ff;
   logic signed [31:0] t_ff;
   logic signed [65:0] prod_ff;
   logic signed [31:0] res_ff [NL+1];

   logic [1:0] status_ff;
   logic signed [31:0] rd_ff;
   logic signed [31:0] rl_ff [NL];
   logic [2:0] rc_ff;

   logic [2:0] cnt_raw, cnt_sat;
   logic [blti_pkg::IdxW-1:0] idx, idx_m1;
   logic signed [32:0] bound;
   logic signed [32:0] num_d, den_d, num_abs, den_abs;
   logic [32:0] rem_sh;
   logic signed [33:0] rem_try;
   logic [QW-1:0] quo_next;
   logic signed [31:0] t_next;
   logic signed [65:0] acc;
   logic signed [65:0] fl;

   assign idx = cmd.idx;
   assign idx_m1 = cmd.idx - 1'b1;
   assign cnt_raw = req_tdata[164:162];
   assign cnt_sat = (cnt_raw > 3'(NL)) ? 3'(NL) : cnt_raw;
   assign bound = 33'(q_ff) + $signed({17'd0, tol_ff});

   assign stat.used = used_ff;
   assign stat.op = blti_pkg::opcode_type'(op_ff);
   assign stat.prev_gt = dist_mem[idx_m1] > q_ff;
   assign stat.le_bound = 33'(dist_mem[idx]) <= bound;
   assign stat.lerp = lerp_ff;

   // Hold configuration and the entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         lerp_ff <= 1'b0;
         tol_ff <= 16'(blti_pkg::ToleranceReset);
         used_ff <= '0;
      end else begin
         if (csr_we && csr_index == blti_pkg::CFG_LERP) lerp_ff <= csr_wdata[0];
         if (csr_we && csr_index == blti_pkg::CFG_TOL) tol_ff <= csr_wdata;
         if (cmd.clear_used) used_ff <= '0;
         else if (cmd.write_new) used_ff <= used_ff + 1'b1;
      end
   end

   // Capture the request and maintain the table
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_tdata[1:0];
         q_ff <= req_tdata[33:2];
         ncnt_ff <= cnt_sat;
         for (int k = 0; k < NL; k++)
            nl_ff[k] <= (3'(k) < cnt_sat) ? req_tdata[34+32*k +: 32] : '0;
      end
      if (cmd.shift_step) begin
         dist_mem[idx] <= dist_mem[idx_m1];
         cnt_mem[idx] <= cnt_mem[idx_m1];
         lim_mem[idx] <= lim_mem[idx_m1];
      end
      if (cmd.write_new) begin
         dist_mem[idx] <= q_ff;
         cnt_mem[idx] <= ncnt_ff;
         lim_mem[idx] <= nl_ff;
      end
      if (cmd.rd_found) begin
         da_ff <= dist_mem[idx];
         ca_ff <= cnt_mem[idx];
         la_ff <= lim_mem[idx];
      end
      if (cmd.rd_next) begin
         db_ff <= dist_mem[idx];
         lb_ff <= lim_mem[idx];
      end
   end

   // Restoring divide of |num|<<FB by |den|, one quotient bit a step
   assign num_d = 33'(q_ff) - 33'(da_ff);
   assign den_d = 33'(db_ff) - 33'(da_ff);
   assign num_abs = num_d[32] ? -num_d : num_d;
   assign den_abs = den_d[32] ? -den_d : den_d;
   assign rem_sh = {rem_ff, quo_ff[QW-1]};
   assign rem_try = $signed({1'b0, rem_sh}) - $signed({2'b00, den_ff});
   assign quo_next = {quo_ff[QW-2:0], ~rem_try[33]};

   // Apply the sign and saturate the quotient to t
   always_comb begin
      if (!neg_ff) begin
         if (quo_next > QW'(32'h7FFFFFFF)) t_next = 32'sh7FFFFFFF;
         else t_next = $signed(quo_next[31:0]);
      end else begin
         if (quo_next > QW'(32'h80000000)) t_next = 32'sh80000000;
         else t_next = $signed(-quo_next[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= {num_abs[31:0], {FB{1'b0}}};
         den_ff <= den_abs[31:0];
         neg_ff <= num_d[32] ^ den_d[32];
      end
      if (cmd.div_step) begin
         quo_ff <= quo_next;
         rem_ff <= rem_try[33] ? rem_sh[31:0] : rem_try[31:0];
         t_ff <= t_next;
      end
   end

   function automatic logic [blti_pkg::LimW-1:0] LimIdx(input logic [blti_pkg::LimW:0] l);
      logic [blti_pkg::LimW:0] m;
      m = l - 1'b1;
      return m[blti_pkg::LimW-1:0];
   endfunction

   // Multiply one lane: lane 0 distance, then limits
   logic signed [31:0] a_sel, b_sel;
   logic signed [31:0] t_eff;
   always_comb begin
      a_sel = da_ff;
      b_sel = db_ff;
      if (cmd.lane != '0) begin
         a_sel = la_ff[LimIdx(cmd.lane)];
         b_sel = lb_ff[LimIdx(cmd.lane)];
      end
   end

   assign t_eff = (db_ff == da_ff) ? 32'sd0 : t_ff;
   assign fl = prod_ff >>> FB;
   assign acc = 66'(a_sel) + fl;

   always_ff @(posedge clock) begin
      if (cmd.mul_step) prod_ff <= (33'(b_sel) - 33'(a_sel)) * 66'(t_eff);
      if (cmd.fin_step) begin
         if (acc > 66'sh7FFFFFFF) res_ff[cmd.lane] <= 32'sh7FFFFFFF;
         else if (acc < -66'sh80000000) res_ff[cmd.lane] <= 32'sh80000000;
         else res_ff[cmd.lane] <= acc[31:0];
      end
   end

   // Register the response fields
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= cmd.status;
         case (cmd.rsp_sel)
            blti_pkg::SEL_FOUND: begin
               rd_ff <= da_ff;
               rc_ff <= ca_ff;
               rl_ff <= la_ff;
            end
            blti_pkg::SEL_LERP: begin
               rd_ff <= res_ff[0];
               rc_ff <= ca_ff;
               for (int k = 0; k < NL; k++)
                  rl_ff[k] <= (3'(k) < ca_ff) ? res_ff[k+1] : '0;
            end
            default: begin
               rd_ff <= '0;
               rc_ff <= '0;
               for (int k = 0; k < NL; k++) rl_ff[k] <= '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[1:0] = status_ff;
      rsp_tdata[33:2] = rd_ff;
      for (int k = 0; k < NL; k++) rsp_tdata[34+32*k +: 32] = rl_ff[k];
      rsp_tdata[164:162] = rc_ff;
   end

endmodule

[hdl/breakpoint_limit_table_interp_top.sv]
// Breakpoint limit table: clear, insert (kept sorted) and query with optional
// linear interpolation, all values signed Q16.16. One request is handled at a
// time. A clear, a full-table insert or a query of an empty table goes
// straight to the response; an insert first moves each larger entry up one
// place, a query searches the used entries linearly, and an interpolating
// query adds the 48-step restoring divider for t and five multiply lanes,
// each a multiply step and an accumulate step. The block is ready again as
// soon as the response turns valid; a response still waiting on the
// receiver holds the next one back. Write the registers only while no
// request is in flight.
module breakpoint_limit_table_interp_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode, item_distance, entry_limit_0..3, entry_degree_count
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, result_distance, result_limit_0..3, result_degree_count
   output logic [167:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   blti_pkg::cmd_type  cmd;
   blti_pkg::stat_type stat;

   blti_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .cmd(cmd)
   );

   blti_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_tdata(req_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_tdata(rsp_tdata)
   );

endmodule
